// ===== design/pdu_pkg.sv =====
`timescale 1ns / 1ps

package pdu_pkg;

  // fixed field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 31;

  // defaults for the top-level parameters
  localparam int unsigned MaxSeqBytesDef = 6;
  localparam int unsigned QueueDepthDef  = 4;

  // continuation byte test: top two bits 10
  localparam logic [ByteW-1:0] ContMask = 8'b1100_0000;
  localparam logic [ByteW-1:0] ContTag  = 8'b1000_0000;

  // what the back end does with a queued operation
  typedef enum logic [1:0] {
    OP_CP,     // emit val as minimal utf-8
    OP_RAW,    // emit val[7:0] as it is
    OP_EMPTY   // closing result without a byte
  } op_kind_e;

  typedef struct packed {
    op_kind_e         kind;
    logic [CpW-1:0]   val;
    logic             last;
    logic             err;
  } op_t;

endpackage

// ===== design/pdu_opq.sv =====
`timescale 1ns / 1ps

module pdu_opq #(
  parameter int unsigned DEPTH = pdu_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pdu_pkg::op_t  op_i,
  output logic          full_o,
  input  logic          pop_i,
  output pdu_pkg::op_t  op_o,
  output logic          valid_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  pdu_pkg::op_t    mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr, rd;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rptr_q];
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (rd) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (wr && !rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (rd && !wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= op_i;
    end
  end

endmodule

// ===== design/pdu_front.sv =====
`timescale 1ns / 1ps

module pdu_front #(
  parameter int unsigned MAX_SEQ_BYTES = pdu_pkg::MaxSeqBytesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [pdu_pkg::ByteW-1:0]  char_i,
  input  logic                       eos_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  output logic                       push_o,
  output pdu_pkg::op_t               op_o,
  input  logic                       full_i
);

  localparam int unsigned HoldDepth = MAX_SEQ_BYTES - 2;
  localparam int unsigned HcW       = $clog2(HoldDepth + 1);
  localparam int unsigned HiW       = $clog2(HoldDepth);
  localparam int unsigned CpW       = pdu_pkg::CpW;
  localparam int unsigned ByteW     = pdu_pkg::ByteW;

  localparam logic [ByteW-1:0] ChPercent = 8'h25;
  localparam logic [ByteW-1:0] Ch0       = 8'h30;
  localparam logic [ByteW-1:0] Ch9       = 8'h39;
  localparam logic [ByteW-1:0] ChUpA     = 8'h41;
  localparam logic [ByteW-1:0] ChUpF     = 8'h46;
  localparam logic [ByteW-1:0] ChLoA     = 8'h61;
  localparam logic [ByteW-1:0] ChLoF     = 8'h66;
  localparam logic [ByteW-1:0] LeadMin   = 8'b1100_0000;

  typedef enum logic [1:0] {ST_IDLE, ST_LEAD, ST_HELD, ST_MAIN} state_e;
  typedef enum logic [1:0] {PH_NONE, PH_FIRST, PH_SECOND} phase_e;

  // {ok, value}
  function automatic logic [4:0] hex_val(input logic [ByteW-1:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= Ch0 && c <= Ch9) begin
      r = {1'b1, 4'(c - Ch0)};
    end else if (c >= ChLoA && c <= ChLoF) begin
      r = {1'b1, 4'(c - ChLoA + 8'd10)};
    end else if (c >= ChUpA && c <= ChUpF) begin
      r = {1'b1, 4'(c - ChUpA + 8'd10)};
    end
    return r;
  endfunction

  // sequence length announced by a lead byte
  function automatic logic [2:0] lead_len(input logic [ByteW-1:0] b);
    logic [2:0] n;
    if ((b & 8'b1111_1100) == 8'b1111_1100) begin
      n = 3'd6;
    end else if ((b & 8'b1111_1000) == 8'b1111_1000) begin
      n = 3'd5;
    end else if ((b & 8'b1111_0000) == 8'b1111_0000) begin
      n = 3'd4;
    end else if ((b & 8'b1110_0000) == 8'b1110_0000) begin
      n = 3'd3;
    end else begin
      n = 3'd2;
    end
    return n;
  endfunction

  state_e           state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [3:0]       nib_q, nib_d;
  logic             utf8_q, utf8_d;
  logic [ByteW-1:0] lead_q, lead_d;
  logic [2:0]       rem_q, rem_d;
  logic [HcW-1:0]   hcnt_q, hcnt_d;
  logic [CpW-1:0]   cp_q, cp_d;
  logic             failed_q, failed_d;
  logic             eos_q, eos_d;
  logic             any_q, any_d;
  logic [HiW-1:0]   hidx_q, hidx_d;
  logic             blast_q, blast_d;
  logic             berr_q, berr_d;
  logic             bret_q, bret_d;
  logic [ByteW-1:0] chr_q;
  logic [ByteW-1:0] held_q [HoldDepth];

  logic [ByteW-1:0] c_sel;
  logic             e_sel;
  logic [4:0]       hx;
  logic [ByteW-1:0] dbyte;
  logic             seq_held;
  logic             pre_brk;
  logic             bad_hex;
  logic             any_base;
  logic             do_main;
  logic             m_push;
  pdu_pkg::op_kind_e m_kind;
  logic [CpW-1:0]   m_val;
  logic [CpW-1:0]   cp_acc;
  logic [2:0]       ln;
  logic             end_err;
  logic             brk_end;
  logic             hwe;
  logic             held_last;
  logic             accept;

  assign c_sel    = (state_q == ST_IDLE) ? char_i : chr_q;
  assign e_sel    = (state_q == ST_IDLE) ? eos_i : eos_q;
  assign hx       = hex_val(c_sel);
  assign bad_hex  = (phase_q != PH_NONE) && !hx[4];
  assign dbyte    = {nib_q, hx[3:0]};
  assign seq_held = (rem_q != 3'd0);
  assign cp_acc   = {cp_q[CpW-7:0], dbyte[5:0]};
  assign ln       = lead_len(dbyte);
  assign any_base = (state_q == ST_IDLE) ? 1'b0 : any_q;
  assign held_last = ((HcW'(hidx_q) + HcW'(1)) == hcnt_q);
  assign ready_o  = (state_q == ST_IDLE) && !full_i;
  assign accept   = valid_i && ready_o;

  // a held sequence is broken by anything but an escaped continuation byte
  always_comb begin
    pre_brk = 1'b0;
    if (phase_q != PH_NONE) begin
      if (!hx[4]) begin
        pre_brk = seq_held;
      end else if (phase_q == PH_SECOND) begin
        pre_brk = seq_held && ((dbyte & pdu_pkg::ContMask) != pdu_pkg::ContTag);
      end
    end else if (c_sel != ChPercent) begin
      pre_brk = seq_held;
    end
  end

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    nib_d    = nib_q;
    utf8_d   = utf8_q;
    lead_d   = lead_q;
    rem_d    = rem_q;
    hcnt_d   = hcnt_q;
    cp_d     = cp_q;
    failed_d = failed_q;
    eos_d    = eos_q;
    any_d    = any_q;
    hidx_d   = hidx_q;
    blast_d  = blast_q;
    berr_d   = berr_q;
    bret_d   = bret_q;
    push_o   = 1'b0;
    op_o     = '0;
    do_main  = 1'b0;
    m_push   = 1'b0;
    m_kind   = pdu_pkg::OP_CP;
    m_val    = '0;
    end_err  = 1'b0;
    brk_end  = 1'b0;
    hwe      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          eos_d = eos_i;
          any_d = 1'b0;
          if (pre_brk) begin
            state_d = ST_LEAD;
            bret_d  = 1'b1;
            blast_d = eos_i && bad_hex;
            berr_d  = eos_i && bad_hex;
          end else begin
            do_main = 1'b1;
          end
        end
      end
      ST_MAIN: begin
        do_main = !full_i;
      end
      ST_LEAD: begin
        if (!full_i) begin
          push_o      = 1'b1;
          op_o.kind   = pdu_pkg::OP_CP;
          op_o.val    = CpW'(lead_q);
          op_o.last   = blast_q && (hcnt_q == '0);
          op_o.err    = berr_q && (hcnt_q == '0);
          any_d       = 1'b1;
          if (hcnt_q != '0) begin
            utf8_d  = 1'b0;
            hidx_d  = '0;
            state_d = ST_HELD;
          end else begin
            brk_end = 1'b1;
          end
        end
      end
      ST_HELD: begin
        if (!full_i) begin
          push_o    = 1'b1;
          op_o.kind = pdu_pkg::OP_CP;
          op_o.val  = CpW'(held_q[hidx_q]);
          op_o.last = blast_q && held_last;
          op_o.err  = berr_q && held_last;
          if (held_last) begin
            brk_end = 1'b1;
          end else begin
            hidx_d = hidx_q + HiW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (brk_end) begin
      rem_d  = 3'd0;
      hcnt_d = '0;
      cp_d   = '0;
      if (bret_q) begin
        state_d = ST_MAIN;
      end else begin
        // break at the string end closes the string
        state_d  = ST_IDLE;
        phase_d  = PH_NONE;
        utf8_d   = 1'b1;
        lead_d   = '0;
        failed_d = 1'b0;
      end
    end

    if (do_main) begin
      if (phase_q != PH_NONE) begin
        if (!hx[4]) begin
          failed_d = 1'b1;
          phase_d  = PH_NONE;
        end else if (phase_q == PH_FIRST) begin
          nib_d   = hx[3:0];
          phase_d = PH_SECOND;
        end else begin
          phase_d = PH_NONE;
          if (seq_held) begin
            // continuation byte of the held sequence
            rem_d = rem_q - 3'd1;
            if (rem_q == 3'd1) begin
              m_push = 1'b1;
              m_val  = cp_acc;
              hcnt_d = '0;
              cp_d   = '0;
            end else begin
              cp_d = cp_acc;
              if (hcnt_q < HcW'(HoldDepth)) begin
                hwe    = 1'b1;
                hcnt_d = hcnt_q + HcW'(1);
              end
            end
          end else if (!utf8_q || dbyte < pdu_pkg::ContTag) begin
            m_push = 1'b1;
            m_val  = CpW'(dbyte);
          end else if (dbyte < LeadMin) begin
            // stray continuation drops to latin-1
            utf8_d = 1'b0;
            m_push = 1'b1;
            m_val  = CpW'(dbyte);
          end else if (ln > 3'(MAX_SEQ_BYTES)) begin
            m_push = 1'b1;
            m_val  = CpW'(dbyte);
          end else begin
            lead_d = dbyte;
            cp_d   = CpW'(dbyte & (8'h7F >> ln));
            rem_d  = ln - 3'd1;
            hcnt_d = '0;
          end
        end
      end else if (c_sel == ChPercent) begin
        phase_d = PH_FIRST;
      end else begin
        m_push = 1'b1;
        m_kind = pdu_pkg::OP_RAW;
        m_val  = CpW'(c_sel);
      end

      end_err   = failed_d || (phase_d != PH_NONE);
      push_o    = m_push;
      op_o.kind = m_kind;
      op_o.val  = m_val;
      any_d     = any_base || m_push;
      state_d   = ST_IDLE;

      if (e_sel) begin
        if (rem_d != 3'd0) begin
          // sequence still open at the end: break it, then close
          state_d = ST_LEAD;
          bret_d  = 1'b0;
          blast_d = 1'b1;
          berr_d  = end_err;
        end else begin
          if (m_push) begin
            op_o.last = 1'b1;
            op_o.err  = end_err;
          end else if (!any_base) begin
            push_o    = 1'b1;
            op_o.kind = pdu_pkg::OP_EMPTY;
            op_o.val  = '0;
            op_o.last = 1'b1;
            op_o.err  = end_err;
          end
          phase_d  = PH_NONE;
          utf8_d   = 1'b1;
          lead_d   = '0;
          rem_d    = 3'd0;
          hcnt_d   = '0;
          cp_d     = '0;
          failed_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      phase_q  <= PH_NONE;
      nib_q    <= '0;
      utf8_q   <= 1'b1;
      lead_q   <= '0;
      rem_q    <= 3'd0;
      hcnt_q   <= '0;
      cp_q     <= '0;
      failed_q <= 1'b0;
      eos_q    <= 1'b0;
      any_q    <= 1'b0;
      hidx_q   <= '0;
      blast_q  <= 1'b0;
      berr_q   <= 1'b0;
      bret_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      nib_q    <= nib_d;
      utf8_q   <= utf8_d;
      lead_q   <= lead_d;
      rem_q    <= rem_d;
      hcnt_q   <= hcnt_d;
      cp_q     <= cp_d;
      failed_q <= failed_d;
      eos_q    <= eos_d;
      any_q    <= any_d;
      hidx_q   <= hidx_d;
      blast_q  <= blast_d;
      berr_q   <= berr_d;
      bret_q   <= bret_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      chr_q <= char_i;
    end
    if (hwe) begin
      held_q[hcnt_q[HiW-1:0]] <= dbyte;
    end
  end

endmodule

// ===== design/pdu_back.sv =====
`timescale 1ns / 1ps

module pdu_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       op_valid_i,
  input  pdu_pkg::op_t               op_i,
  output logic                       pop_o,
  output logic [pdu_pkg::ByteW-1:0]  tdata_o,
  output logic [1:0]                 tuser_o,
  output logic                       tlast_o,
  output logic                       tvalid_o,
  input  logic                       tready_i
);

  localparam int unsigned CpW   = pdu_pkg::CpW;
  localparam int unsigned ByteW = pdu_pkg::ByteW;

  // byte count of the minimal utf-8 form
  function automatic logic [2:0] seq_len(input logic [CpW-1:0] cp);
    logic [2:0] n;
    if (cp[CpW-1:7] == '0) begin
      n = 3'd1;
    end else if (cp[CpW-1:11] == '0) begin
      n = 3'd2;
    end else if (cp[CpW-1:16] == '0) begin
      n = 3'd3;
    end else if (cp[CpW-1:21] == '0) begin
      n = 3'd4;
    end else if (cp[CpW-1:26] == '0) begin
      n = 3'd5;
    end else begin
      n = 3'd6;
    end
    return n;
  endfunction

  // byte k of an n byte encoding, k = n-1 is the lead
  function automatic logic [ByteW-1:0] utf8_byte(input logic [CpW-1:0] cp,
                                                 input logic [2:0] n,
                                                 input logic [2:0] k);
    logic [ByteW-1:0] r;
    r = cp[ByteW-1:0];
    if (n != 3'd1) begin
      if (k == n - 3'd1) begin
        unique case (n)
          3'd2:    r = 8'b1100_0000 | {3'b000, cp[10:6]};
          3'd3:    r = 8'b1110_0000 | {4'b0000, cp[15:12]};
          3'd4:    r = 8'b1111_0000 | {5'b00000, cp[20:18]};
          3'd5:    r = 8'b1111_1000 | {6'b000000, cp[25:24]};
          default: r = 8'b1111_1100 | {7'b0000000, cp[30]};
        endcase
      end else begin
        unique case (k)
          3'd0:    r = pdu_pkg::ContTag | {2'b00, cp[5:0]};
          3'd1:    r = pdu_pkg::ContTag | {2'b00, cp[11:6]};
          3'd2:    r = pdu_pkg::ContTag | {2'b00, cp[17:12]};
          3'd3:    r = pdu_pkg::ContTag | {2'b00, cp[23:18]};
          default: r = pdu_pkg::ContTag | {2'b00, cp[29:24]};
        endcase
      end
    end
    return r;
  endfunction

  logic             cur_valid_q;
  pdu_pkg::op_t     cur_q;
  logic [2:0]       n_q;
  logic [2:0]       k_q;
  logic             ov_q;
  logic [ByteW-1:0] obyte_q;
  logic             ohas_q;
  logic             olast_q;
  logic             oerr_q;

  logic             out_free;
  logic             emit;
  logic             fin;
  logic [2:0]       n_new;
  logic [ByteW-1:0] byte_cur;
  logic             has_cur;

  assign out_free = !ov_q || tready_i;
  assign emit     = out_free && cur_valid_q;
  assign fin      = emit && (k_q == 3'd0);
  assign pop_o    = op_valid_i && (!cur_valid_q || fin);
  assign n_new    = (op_i.kind == pdu_pkg::OP_CP) ? seq_len(op_i.val) : 3'd1;

  always_comb begin
    byte_cur = '0;
    has_cur  = 1'b1;
    unique case (cur_q.kind)
      pdu_pkg::OP_EMPTY: has_cur = 1'b0;
      pdu_pkg::OP_RAW:   byte_cur = cur_q.val[ByteW-1:0];
      default:           byte_cur = utf8_byte(cur_q.val, n_q, k_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      ov_q        <= 1'b0;
      k_q         <= 3'd0;
      n_q         <= 3'd1;
    end else begin
      if (pop_o) begin
        cur_valid_q <= 1'b1;
        n_q         <= n_new;
        k_q         <= n_new - 3'd1;
      end else if (fin) begin
        cur_valid_q <= 1'b0;
      end else if (emit) begin
        k_q <= k_q - 3'd1;
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= op_i;
    end
    if (emit) begin
      obyte_q <= byte_cur;
      ohas_q  <= has_cur;
      olast_q <= cur_q.last && (k_q == 3'd0);
      oerr_q  <= cur_q.err && (k_q == 3'd0);
    end
  end

  assign tvalid_o = ov_q;
  assign tdata_o  = obyte_q;
  assign tuser_o  = {oerr_q, ohas_q};
  assign tlast_o  = olast_q;

endmodule

// ===== design/percent_decoder_utf8_normalize.sv =====
`timescale 1ns / 1ps

// channel   dir  tdata            tuser (bit 0 up)          tlast
// s_axis    in   in_char[7:0]     -                         end_of_string
// m_axis    out  out_byte[7:0]    has_byte, decode_error    last
//
// a character that yields at most one operation is handled in the cycle it is accepted; a broken
// utf-8 sequence first replays the lead and each held continuation as its own code point,
// then handles the breaking character unless the string end broke it
// the back end sends one output byte per cycle while the downstream side accepts it, and
// all bytes pass through its single output register
// reset clears all control state at once; the operation queue lets either side stall alone

module percent_decoder_utf8_normalize #(
  parameter int unsigned MAX_SEQ_BYTES = pdu_pkg::MaxSeqBytesDef,
  parameter int unsigned QUEUE_DEPTH   = pdu_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input characters
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_char
  input  logic        s_axis_tlast_i,   // end_of_string
  // decoded bytes
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser_o,   // [0] has_byte, [1] decode_error
  output logic        m_axis_tlast_o    // last
);

  // front to queue
  logic         fr_push;
  pdu_pkg::op_t fr_op;
  logic         q_full;

  // queue to back end
  logic         q_valid;
  pdu_pkg::op_t q_op;
  logic         bk_pop;

  // escape decoding, sequence gathering and replay of broken sequences
  pdu_front #(
    .MAX_SEQ_BYTES (MAX_SEQ_BYTES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (s_axis_tdata_i),
    .eos_i   (s_axis_tlast_i),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .push_o  (fr_push),
    .op_o    (fr_op),
    .full_i  (q_full)
  );

  // short operation queue between the two halves
  pdu_opq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .op_i    (fr_op),
    .full_o  (q_full),
    .pop_i   (bk_pop),
    .op_o    (q_op),
    .valid_o (q_valid)
  );

  // expands each operation into output bytes, one per transfer
  pdu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (q_valid),
    .op_i       (q_op),
    .pop_o      (bk_pop),
    .tdata_o    (m_axis_tdata_o),
    .tuser_o    (m_axis_tuser_o),
    .tlast_o    (m_axis_tlast_o),
    .tvalid_o   (m_axis_tvalid_o),
    .tready_i   (m_axis_tready_i)
  );

endmodule
